[rtl/usbmidi_pkg.sv]
package usbmidi_pkg;

    localparam int SYSEX_DEPTH_DEF = 32;

    // only the first bytes of a sysex message are ever inspected
    localparam int HDR_LEN = 7;

    localparam logic [7:0] CIN_SYSEX_START = 8'd4;
    localparam logic [7:0] CIN_SYSEX_END1  = 8'd5;
    localparam logic [7:0] CIN_SYSEX_END2  = 8'd6;
    localparam logic [7:0] CIN_SYSEX_END3  = 8'd7;
    localparam logic [7:0] CIN_NOTE_OFF    = 8'd8;
    localparam logic [7:0] CIN_NOTE_ON     = 8'd9;
    localparam logic [7:0] CIN_CTRL        = 8'd11;
    localparam logic [7:0] CIN_SYSEX_BYTE  = 8'd15;

    localparam logic [7:0] CC_BAR_C  = 8'd0;
    localparam logic [7:0] CC_BAR_D  = 8'd1;
    localparam logic [7:0] CC_VU_1ST = 8'd2;
    localparam logic [7:0] CC_VU_2ND = 8'd3;

    localparam logic [7:0] SX_CMD_LEDS_ALL = 8'd0;
    localparam logic [7:0] SX_CMD_LEDS_AB  = 8'd1;
    localparam logic [7:0] SX_CMD_VU       = 8'd2;

    localparam logic [7:0] SX_START = 8'hF0;
    localparam logic [7:0] SX_END   = 8'hF7;

    function automatic logic [7:0] bar_mask(input logic [3:0] idx);
        logic [7:0] m;
        case (idx)
            4'd0:    m = 8'h00;
            4'd1:    m = 8'h80;
            4'd2:    m = 8'hA0;
            4'd3:    m = 8'hA8;
            4'd4:    m = 8'hAA;
            4'd5:    m = 8'hAB;
            4'd6:    m = 8'hAF;
            4'd7:    m = 8'hBF;
            4'd8:    m = 8'hFF;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

[rtl/usb_midi_led_command_decoder.sv]
// USB-MIDI event packet decoder driving LED banks and VU levels.
//
// Input channel (in_valid/in_ready): one four-byte event packet per beat.
// Output channel (out_valid/out_ready): one result beat per packet, showing
// the four LED banks, both VU levels and the VU-mode flag as they stand after
// that packet, plus sysex_finished when the packet closed a sysex message.
//
// A packet is captured in an input register, then decoded and applied to the
// state once the output register is free, and its result is held there. One
// packet per cycle is sustained while out_ready stays high. The decode is a
// single pass over fixed-index state: sysex bytes that matter (the first
// seven) are kept in registers, the rest only counted.
//
// The output register holds while out_ready is low; the input register then
// fills and in_ready drops until the output beat is taken.
// Reset clears LEDs and VU levels, sets VU mode and empties the sysex store.
module usb_midi_led_command_decoder
    import usbmidi_pkg::*;
#(
    parameter int SYSEX_DEPTH = SYSEX_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] code_index_number,
    input  logic [7:0] status_byte,
    input  logic [7:0] data_byte_a,
    input  logic [7:0] data_byte_b,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] led_bank_a,
    output logic [7:0] led_bank_b,
    output logic [7:0] led_bank_c,
    output logic [7:0] led_bank_d,
    output logic [7:0] vu_level_first,
    output logic [7:0] vu_level_second,
    output logic       vu_mode,
    output logic       sysex_finished
);

    localparam int FILL_W = $clog2(SYSEX_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_LIM = SUM_W'(SYSEX_DEPTH);

    logic             s1_valid_reg;
    logic [7:0]       cin_reg, b1_reg, b2_reg, b3_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       led_reg [4];
    logic [7:0]       led_next [4];
    logic [7:0]       vu_reg [2];
    logic [7:0]       vu_next [2];
    logic             mode_reg, mode_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]       hdr_reg [HDR_LEN];
    logic [7:0]       hdr_next [HDR_LEN];
    logic             fin_reg, fin_next;

    logic             advance;
    logic [7:0]       code_eff;
    logic [7:0]       pay [3];
    logic [1:0]       sx_count;
    logic             sx_ends;
    logic [SUM_W-1:0] sx_sum;
    logic             sx_fits;
    logic [7:0]       sx_last;
    logic             sx_ok;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    assign pay[0] = b1_reg;
    assign pay[1] = b2_reg;
    assign pay[2] = b3_reg;

    assign code_eff = (cin_reg == CIN_NOTE_ON && b3_reg == 8'd0) ? CIN_NOTE_OFF : cin_reg;

    always_comb
    begin
        case (cin_reg)
            CIN_SYSEX_START:
            begin
                sx_count = 2'd3;
                sx_ends  = 1'b0;
                sx_last  = b3_reg;
            end
            CIN_SYSEX_END1:
            begin
                sx_count = 2'd1;
                sx_ends  = 1'b1;
                sx_last  = b1_reg;
            end
            CIN_SYSEX_END2:
            begin
                sx_count = 2'd2;
                sx_ends  = 1'b1;
                sx_last  = b2_reg;
            end
            CIN_SYSEX_END3:
            begin
                sx_count = 2'd3;
                sx_ends  = 1'b1;
                sx_last  = b3_reg;
            end
            default:
            begin
                sx_count = 2'd1;
                sx_ends  = 1'b0;
                sx_last  = b1_reg;
            end
        endcase
    end

    assign sx_sum  = {1'b0, fill_reg} + SUM_W'(sx_count);
    assign sx_fits = (sx_sum <= DEPTH_LIM);

    always_comb
    begin
        for (int k = 0; k < HDR_LEN; k++)
        begin
            hdr_next[k] = hdr_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                if (sx_fits && (2'(i) < sx_count) &&
                    ({1'b0, fill_reg} + SUM_W'(i) == SUM_W'(k)))
                begin
                    hdr_next[k] = pay[i];
                end
            end
        end
    end

    // framing check uses the merged header and the last byte of this packet
    assign sx_ok = (sx_sum >= SUM_W'(2)) && (hdr_next[0] == SX_START) && (sx_last == SX_END);

    always_comb
    begin
        for (int j = 0; j < 4; j++)
            led_next[j] = led_reg[j];
        vu_next[0] = vu_reg[0];
        vu_next[1] = vu_reg[1];
        mode_next  = mode_reg;
        fill_next  = fill_reg;
        fin_next   = 1'b0;

        case (code_eff)
            CIN_NOTE_OFF:
            begin
                if (b2_reg[7:5] == 3'd0)
                    led_next[b2_reg[4:3]][b2_reg[2:0]] = 1'b0;
            end
            CIN_NOTE_ON:
            begin
                if (b2_reg[7:5] == 3'd0)
                    led_next[b2_reg[4:3]][b2_reg[2:0]] = 1'b1;
            end
            CIN_CTRL:
            begin
                case (b2_reg)
                    CC_BAR_C:
                    begin
                        mode_next = 1'b0;
                        if (b3_reg <= 8'd8)
                            led_next[2] = ~bar_mask(4'd8 - b3_reg[3:0]);
                    end
                    CC_BAR_D:
                    begin
                        mode_next = 1'b0;
                        if (b3_reg <= 8'd8)
                            led_next[3] = bar_mask(b3_reg[3:0]);
                    end
                    CC_VU_1ST:
                    begin
                        mode_next = 1'b1;
                        if (b3_reg <= 8'd32)
                            vu_next[0] = b3_reg;
                    end
                    CC_VU_2ND:
                    begin
                        mode_next = 1'b1;
                        if (b3_reg <= 8'd32)
                            vu_next[1] = b3_reg;
                    end
                    default:
                    begin
                        if (b2_reg[6:5] == 2'b11)
                        begin
                            mode_next  = 1'b1;
                            vu_next[1] = {2'b00, b2_reg[4:0], b3_reg[6]};
                            vu_next[0] = {2'b00, b3_reg[5:0]};
                        end
                    end
                endcase
            end
            CIN_SYSEX_START, CIN_SYSEX_END1, CIN_SYSEX_END2, CIN_SYSEX_END3,
            CIN_SYSEX_BYTE:
            begin
                if (sx_fits)
                begin
                    fill_next = sx_sum[FILL_W-1:0];
                    if (sx_ends)
                    begin
                        fin_next  = 1'b1;
                        fill_next = '0;
                        if (sx_ok)
                        begin
                            if (hdr_next[1] == SX_CMD_LEDS_ALL && sx_sum >= SUM_W'(8))
                            begin
                                mode_next   = 1'b0;
                                led_next[0] = hdr_next[2] | {hdr_next[6][0], 7'd0};
                                led_next[1] = hdr_next[3] | {hdr_next[6][1], 7'd0};
                                led_next[2] = hdr_next[4] | {hdr_next[6][2], 7'd0};
                                led_next[3] = hdr_next[5] | {hdr_next[6][3], 7'd0};
                            end
                            else if (hdr_next[1] == SX_CMD_LEDS_AB && sx_sum >= SUM_W'(6))
                            begin
                                led_next[0] = hdr_next[2] | {hdr_next[4][0], 7'd0};
                                led_next[1] = hdr_next[3] | {hdr_next[4][1], 7'd0};
                            end
                            else if (hdr_next[1] == SX_CMD_VU && sx_sum >= SUM_W'(5))
                            begin
                                mode_next  = 1'b1;
                                vu_next[0] = hdr_next[2];
                                vu_next[1] = hdr_next[3];
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < 4; j++)
                led_reg[j] <= 8'd0;
            vu_reg[0] <= 8'd0;
            vu_reg[1] <= 8'd0;
            mode_reg  <= 1'b1;
            fill_reg  <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
            begin
                for (int j = 0; j < 4; j++)
                    led_reg[j] <= led_next[j];
                vu_reg[0] <= vu_next[0];
                vu_reg[1] <= vu_next[1];
                mode_reg  <= mode_next;
                fill_reg  <= fill_next;
                fin_reg   <= fin_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cin_reg <= code_index_number;
            b1_reg  <= status_byte;
            b2_reg  <= data_byte_a;
            b3_reg  <= data_byte_b;
        end
        if (advance)
        begin
            for (int k = 0; k < HDR_LEN; k++)
                hdr_reg[k] <= hdr_next[k];
        end
    end

    assign out_valid       = out_valid_reg;
    assign led_bank_a      = led_reg[0];
    assign led_bank_b      = led_reg[1];
    assign led_bank_c      = led_reg[2];
    assign led_bank_d      = led_reg[3];
    assign vu_level_first  = vu_reg[0];
    assign vu_level_second = vu_reg[1];
    assign vu_mode         = mode_reg;
    assign sysex_finished  = fin_reg;

endmodule

[rtl/usbmidi_chk.sv]
module usbmidi_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] led_bank_a,
    input logic       sysex_finished
);

    // a held beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(led_bank_a) && $stable(sysex_finished))
        else $error("output beat changed while stalled");

    // empty output slot means room for a new packet
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with output empty");

    // a packet taken while the output is empty shows up after the input and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |-> ##2 out_valid)
        else $error("result missing two cycles after accept");

    // output valid only rises once an input beat has passed the input and output registers
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a packet");

endmodule

bind usb_midi_led_command_decoder usbmidi_chk u_usbmidi_chk
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .led_bank_a     (led_bank_a),
    .sysex_finished (sysex_finished)
);

[tb/sv/midi_led_checker.sv]
module midi_led_checker
    import usbmidi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] code_index_number,
    input  logic [7:0] status_byte,
    input  logic [7:0] data_byte_a,
    input  logic [7:0] data_byte_b,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] led_bank_a,
    input  logic [7:0] led_bank_b,
    input  logic [7:0] led_bank_c,
    input  logic [7:0] led_bank_d,
    input  logic [7:0] vu_level_first,
    input  logic [7:0] vu_level_second,
    input  logic       vu_mode,
    input  logic       sysex_finished,
    output int         mismatch_count,
    output int         results_owed
);

    typedef struct packed {
        logic [7:0] bank_a;
        logic [7:0] bank_b;
        logic [7:0] bank_c;
        logic [7:0] bank_d;
        logic [7:0] vu_first;
        logic [7:0] vu_second;
        logic       vu_mode;
        logic       sysex_done;
    } panel_t;

    panel_t     owed_panels[$];
    panel_t     seen;
    panel_t     want;
    logic [7:0] led_state [4];
    logic [7:0] vu_state [2];
    logic       vu_integrated;
    logic [7:0] sysex_bytes [SYSEX_DEPTH_DEF];
    int         sysex_count;
    int         errors = 0;

    function automatic logic [7:0] bar_steps(input int n);
        logic [7:0] m;
        case (n)
            0:       m = 8'h00;
            1:       m = 8'h80;
            2:       m = 8'hA0;
            3:       m = 8'hA8;
            4:       m = 8'hAA;
            5:       m = 8'hAB;
            6:       m = 8'hAF;
            7:       m = 8'hBF;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] got_v);
        if (exp_v !== got_v)
        begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
        end
    endfunction

    task automatic decode_packet(input logic [7:0] cin, input logic [7:0] s,
                                 input logic [7:0] a, input logic [7:0] b);
        logic [7:0] op;
        logic [7:0] pay [3];
        int         n;
        bit         ends;
        bit         closed;
        panel_t     p;
        op = (cin == CIN_NOTE_ON && b == 8'd0) ? CIN_NOTE_OFF : cin;
        pay[0] = s;
        pay[1] = a;
        pay[2] = b;
        n = 0;
        ends = 1'b0;
        closed = 1'b0;
        case (op)
            CIN_NOTE_OFF:
                if (a < 8'd32)
                    led_state[a[4:3]][a[2:0]] = 1'b0;
            CIN_NOTE_ON:
                if (a < 8'd32)
                    led_state[a[4:3]][a[2:0]] = 1'b1;
            CIN_CTRL:
                case (a)
                    CC_BAR_C:
                    begin
                        vu_integrated = 1'b0;
                        if (b <= 8'd8)
                            led_state[2] = ~bar_steps(8 - int'(b));
                    end
                    CC_BAR_D:
                    begin
                        vu_integrated = 1'b0;
                        if (b <= 8'd8)
                            led_state[3] = bar_steps(int'(b));
                    end
                    CC_VU_1ST:
                    begin
                        vu_integrated = 1'b1;
                        if (b <= 8'd32)
                            vu_state[0] = b;
                    end
                    CC_VU_2ND:
                    begin
                        vu_integrated = 1'b1;
                        if (b <= 8'd32)
                            vu_state[1] = b;
                    end
                    default:
                        if (a[6:5] == 2'b11)
                        begin
                            vu_integrated = 1'b1;
                            vu_state[1] = {2'b00, a[4:0], b[6]};
                            vu_state[0] = {2'b00, b[5:0]};
                        end
                endcase
            CIN_SYSEX_START:
                n = 3;
            CIN_SYSEX_END1:
            begin
                n = 1;
                ends = 1'b1;
            end
            CIN_SYSEX_END2:
            begin
                n = 2;
                ends = 1'b1;
            end
            CIN_SYSEX_END3:
            begin
                n = 3;
                ends = 1'b1;
            end
            CIN_SYSEX_BYTE:
                n = 1;
            default:
                ;
        endcase

        // a packet that does not fit is dropped whole
        if (n > 0 && sysex_count + n <= SYSEX_DEPTH_DEF)
        begin
            for (int i = 0; i < n; i++)
                sysex_bytes[sysex_count + i] = pay[i];
            sysex_count += n;
            if (ends)
            begin
                closed = 1'b1;
                if (sysex_count >= 2 && sysex_bytes[0] == SX_START &&
                    sysex_bytes[sysex_count - 1] == SX_END)
                begin
                    case (sysex_bytes[1])
                        SX_CMD_LEDS_ALL:
                            if (sysex_count >= 8)
                            begin
                                vu_integrated = 1'b0;
                                for (int k = 0; k < 4; k++)
                                    led_state[k] = sysex_bytes[2 + k] |
                                                   {sysex_bytes[6][k], 7'd0};
                            end
                        SX_CMD_LEDS_AB:
                            if (sysex_count >= 6)
                                for (int k = 0; k < 2; k++)
                                    led_state[k] = sysex_bytes[2 + k] |
                                                   {sysex_bytes[4][k], 7'd0};
                        SX_CMD_VU:
                            if (sysex_count >= 5)
                            begin
                                vu_integrated = 1'b1;
                                vu_state[0] = sysex_bytes[2];
                                vu_state[1] = sysex_bytes[3];
                            end
                        default:
                            ;
                    endcase
                end
                sysex_count = 0;
            end
        end

        p.bank_a = led_state[0];
        p.bank_b = led_state[1];
        p.bank_c = led_state[2];
        p.bank_d = led_state[3];
        p.vu_first = vu_state[0];
        p.vu_second = vu_state[1];
        p.vu_mode = vu_integrated;
        p.sysex_done = closed;
        owed_panels.push_back(p);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (led_state[k])
                led_state[k] = 8'd0;
            vu_state[0] = 8'd0;
            vu_state[1] = 8'd0;
            vu_integrated = 1'b1;
            sysex_count = 0;
            owed_panels.delete();
            results_owed <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = {led_bank_a, led_bank_b, led_bank_c, led_bank_d,
                        vu_level_first, vu_level_second, vu_mode, sysex_finished};
                if (owed_panels.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat expected none got %h", $time, seen);
                end
                else
                begin
                    want = owed_panels.pop_front();
                    check_field("led_bank_a", want.bank_a, seen.bank_a);
                    check_field("led_bank_b", want.bank_b, seen.bank_b);
                    check_field("led_bank_c", want.bank_c, seen.bank_c);
                    check_field("led_bank_d", want.bank_d, seen.bank_d);
                    check_field("vu_level_first", want.vu_first, seen.vu_first);
                    check_field("vu_level_second", want.vu_second, seen.vu_second);
                    check_field("vu_mode", want.vu_mode, seen.vu_mode);
                    check_field("sysex_finished", want.sysex_done, seen.sysex_done);
                end
            end
            if (in_valid && in_ready)
                decode_packet(code_index_number, status_byte, data_byte_a, data_byte_b);
            results_owed <= owed_panels.size();
        end
        mismatch_count <= errors;
    end

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    import usbmidi_pkg::*;

    localparam int         CYCLE_LIMIT     = 100000;
    localparam int         TOTAL_PACKETS   = 1350;
    localparam logic [7:0] CIN_UNUSED_LOW  = 8'h00;
    localparam logic [7:0] CIN_UNUSED_HIGH = 8'hFF;
    localparam logic [7:0] CC_DUAL_VU_TOP  = 8'h7F;
    localparam logic [7:0] CC_UNMAPPED     = 8'h5F;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] code_index_number;
    logic [7:0] status_byte;
    logic [7:0] data_byte_a;
    logic [7:0] data_byte_b;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] led_bank_a;
    logic [7:0] led_bank_b;
    logic [7:0] led_bank_c;
    logic [7:0] led_bank_d;
    logic [7:0] vu_level_first;
    logic [7:0] vu_level_second;
    logic       vu_mode;
    logic       sysex_finished;
    int         mismatch_count;
    int         results_owed;

    int cycles = 0;
    int packets_sent = 0;
    int sysex_level = 0;
    bit idle_enable = 1'b1;
    bit stall_sink = 1'b0;
    bit stall_served = 1'b0;
    bit allow_lockup = 1'b0;

    always #5 clk = ~clk;

    usb_midi_led_command_decoder dut (.*);

    midi_led_checker panel_check (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // sysex_level tracks store fill so random traffic never wedges the store unless allow_lockup is set
    task automatic send_packet(input logic [7:0] cin, input logic [7:0] s,
                               input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        int         n;
        bit         ends;
        c = cin;
        n = 0;
        ends = 1'b0;
        case (cin)
            CIN_SYSEX_START:
                n = 3;
            CIN_SYSEX_BYTE:
                n = 1;
            CIN_SYSEX_END1:
            begin
                n = 1;
                ends = 1'b1;
            end
            CIN_SYSEX_END2:
            begin
                n = 2;
                ends = 1'b1;
            end
            CIN_SYSEX_END3:
            begin
                n = 3;
                ends = 1'b1;
            end
            default:
                ;
        endcase
        if (n > 0 && !ends && !allow_lockup && sysex_level + n == SYSEX_DEPTH_DEF)
        begin
            c = CIN_SYSEX_END1;
            n = 1;
            ends = 1'b1;
        end
        if (n > 0 && sysex_level + n <= SYSEX_DEPTH_DEF)
            sysex_level = ends ? 0 : sysex_level + n;

        while (idle_enable && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        code_index_number <= c;
        status_byte <= s;
        data_byte_a <= a;
        data_byte_b <= b;
        do
            @(posedge clk);
        while (!in_ready);
        packets_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_sink && !stall_served)
            begin
                stall_served = 1'b1;
                out_ready <= 1'b0;
                repeat (80) @(posedge clk);
            end
            out_ready <= !idle_enable || $urandom_range(99) >= 18;
        end
    end

    initial
    begin
        int         kind;
        int         len;
        int         cut;
        bit         paused;
        logic [7:0] cin;
        logic [7:0] note;
        logic [7:0] val;
        logic [7:0] ctl;
        logic [7:0] cmd;
        logic [7:0] pay [3];
        logic [7:0] msg [$];

        paused = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        code_index_number <= 8'd0;
        status_byte <= 8'd0;
        data_byte_a <= 8'd0;
        data_byte_b <= 8'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_packet(CIN_NOTE_ON, 8'h90, 8'd0, 8'd127);
        send_packet(CIN_NOTE_ON, 8'h9F, 8'd31, 8'd1);
        send_packet(CIN_NOTE_ON, 8'h90, 8'd32, 8'd64);
        send_packet(CIN_NOTE_ON, 8'h90, 8'd0, 8'd0);
        send_packet(CIN_NOTE_OFF, 8'h80, 8'd31, 8'd255);
        send_packet(CIN_NOTE_OFF, 8'h80, 8'd255, 8'd0);
        send_packet(CIN_CTRL, 8'hB0, CC_BAR_C, 8'd3);
        send_packet(CIN_CTRL, 8'hB0, CC_BAR_C, 8'd9);
        send_packet(CIN_CTRL, 8'hB0, CC_BAR_D, 8'd8);
        send_packet(CIN_CTRL, 8'hB0, CC_BAR_D, 8'd255);
        send_packet(CIN_CTRL, 8'hB0, CC_VU_1ST, 8'd32);
        send_packet(CIN_CTRL, 8'hB0, CC_VU_2ND, 8'd33);
        send_packet(CIN_CTRL, 8'hBF, CC_DUAL_VU_TOP, 8'hFF);
        send_packet(CIN_CTRL, 8'hB0, CC_UNMAPPED, 8'd5);
        send_packet(CIN_UNUSED_LOW, 8'hFF, 8'hFF, 8'hFF);
        send_packet(CIN_UNUSED_HIGH, 8'h00, 8'h00, 8'h00);
        send_packet(CIN_SYSEX_START, SX_START, SX_CMD_LEDS_ALL, 8'h11);
        send_packet(CIN_SYSEX_START, 8'h22, 8'h33, 8'h44);
        send_packet(CIN_SYSEX_END2, 8'h0F, SX_END, 8'h00);
        send_packet(CIN_SYSEX_START, SX_START, SX_CMD_VU, 8'd21);
        send_packet(CIN_SYSEX_END2, 8'd20, SX_END, 8'h00);
        send_packet(CIN_SYSEX_END3, SX_START, SX_CMD_LEDS_AB, SX_END);
        send_packet(CIN_SYSEX_BYTE, SX_START, 8'h00, 8'h00);
        send_packet(CIN_SYSEX_START, SX_CMD_LEDS_AB, 8'hAA, 8'h55);
        send_packet(CIN_SYSEX_END2, 8'h03, SX_END, 8'h00);
        send_packet(CIN_SYSEX_END1, 8'h00, 8'hFF, 8'hFF);
        drain_results();

        while (packets_sent < TOTAL_PACKETS)
        begin
            idle_enable = !(packets_sent >= 450 && packets_sent < 700);
            if (packets_sent >= 470)
                stall_sink = 1'b1;
            if (packets_sent >= 900 && !paused)
            begin
                drain_results();
                paused = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 30)
            begin
                note = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(31));
                val = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(255));
                cin = $urandom_range(1) ? CIN_NOTE_ON : CIN_NOTE_OFF;
                send_packet(cin, 8'($urandom_range(255)), note, val);
            end
            else if (kind < 55)
            begin
                case ($urandom_range(5))
                    0: ctl = CC_BAR_C;
                    1: ctl = CC_BAR_D;
                    2: ctl = CC_VU_1ST;
                    3: ctl = CC_VU_2ND;
                    4: ctl = 8'($urandom_range(255)) | 8'h60;
                    default: ctl = 8'($urandom_range(255));
                endcase
                val = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(34));
                send_packet(CIN_CTRL, 8'($urandom_range(255)), ctl, val);
            end
            else if (kind < 88)
            begin
                msg.delete();
                len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(2, 12);
                cmd = ($urandom_range(5) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(2));
                msg.push_back(SX_START);
                if (len > 2)
                    msg.push_back(cmd);
                while (msg.size() < len - 1)
                    msg.push_back(8'($urandom_range(255)));
                msg.push_back(SX_END);
                if ($urandom_range(7) == 0)
                    msg[0] = 8'($urandom_range(255));
                if ($urandom_range(7) == 0)
                    msg[msg.size() - 1] = 8'($urandom_range(255));
                while (msg.size() > 0)
                begin
                    foreach (pay[i])
                        pay[i] = 8'($urandom_range(255));
                    if (msg.size() <= 3 && $urandom_range(5) != 0)
                    begin
                        cut = msg.size();
                        cin = (cut == 1) ? CIN_SYSEX_END1 :
                              (cut == 2) ? CIN_SYSEX_END2 : CIN_SYSEX_END3;
                    end
                    else if (msg.size() >= 3 && $urandom_range(4) != 0)
                    begin
                        cut = 3;
                        cin = CIN_SYSEX_START;
                    end
                    else
                    begin
                        cut = 1;
                        cin = CIN_SYSEX_BYTE;
                    end
                    for (int i = 0; i < cut; i++)
                        pay[i] = msg.pop_front();
                    send_packet(cin, pay[0], pay[1], pay[2]);
                end
            end
            else
            begin
                send_packet(8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 8'($urandom_range(255)));
            end
        end

        // fill the store to the brim; nothing fits afterwards
        idle_enable = 1'b1;
        allow_lockup = 1'b1;
        send_packet(CIN_SYSEX_END1, SX_END, 8'h00, 8'h00);
        send_packet(CIN_SYSEX_BYTE, SX_START, 8'h00, 8'h00);
        repeat (10)
            send_packet(CIN_SYSEX_START, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
        send_packet(CIN_SYSEX_BYTE, SX_END, 8'h00, 8'h00);
        send_packet(CIN_SYSEX_END1, SX_END, 8'h00, 8'h00);
        send_packet(CIN_SYSEX_END3, SX_START, SX_CMD_VU, SX_END);
        send_packet(CIN_SYSEX_START, SX_START, SX_CMD_LEDS_AB, 8'h00);
        send_packet(CIN_NOTE_ON, 8'h90, 8'd7, 8'd100);
        drain_results();
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && results_owed == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
